/* hw/rtl/rational_arithmetic_unit_macros.svh */
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// property that must hold whenever reset is low
`define RAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* hw/rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_LT = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,    // wait for a transaction
    S_PREP,    // decode operands
    S_GCD1,    // gcd of denominators (add/sub)
    S_DIV1,    // divide both denominators by gcd
    S_MUL1,    // cross products
    S_MUL2,    // combine
    S_GCD2,    // gcd of result parts
    S_DIV2,    // reduce
    S_FIN,     // pack result
    S_OUT      // hold result
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic gcd_start;   // load gcd unit with x/y
    logic gcd_sel;     // 0 denominators, 1 result parts
    logic div_start;
    logic div_sel;
    logic mul1;
    logic mul2;
    logic fin;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic early;       // result already decided at prep
    logic addsub;
    logic gcd_done;
    logic div_done;
    logic nm_zero;
  } stat_t;
endpackage

/* hw/rtl/rau_if.sv */
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// valid/ready channels of the rational arithmetic unit
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] lhs_num;
  logic [31:0] lhs_den;
  logic [31:0] rhs_num;
  logic [31:0] rhs_den;
  modport source (output valid, cmd, lhs_num, lhs_den, rhs_num, rhs_den, input ready);
  modport sink   (input valid, cmd, lhs_num, lhs_den, rhs_num, rhs_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [63:0] res_den;
  logic [1:0]  order;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, order, status, input ready);
  modport sink   (input valid, res_num, res_den, order, status, output ready);
endinterface

/* hw/rtl/rau_divider.sv */
// ----------------------------------------------------------------------------
// rau_divider
// restoring divider, two quotients by one divisor, one bit a cycle
// ----------------------------------------------------------------------------
module rau_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend_a,
  input  logic [63:0] dividend_b,
  input  logic [63:0] divisor,
  output logic [63:0] quot_a,
  output logic [63:0] quot_b,
  output logic        done
);
  logic [63:0] qa, qb, ra, rb;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] ta, tb;

  assign ta = {ra, qa[63]};
  assign tb = {rb, qb[63]};

  // shift-subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd0;
      qa <= dividend_a;
      qb <= dividend_b;
      ra <= '0;
      rb <= '0;
    end else if (busy) begin
      if (ta >= {1'b0, divisor}) begin
        ra <= 64'(ta - {1'b0, divisor});
        qa <= {qa[62:0], 1'b1};
      end else begin
        ra <= ta[63:0];
        qa <= {qa[62:0], 1'b0};
      end
      if (tb >= {1'b0, divisor}) begin
        rb <= 64'(tb - {1'b0, divisor});
        qb <= {qb[62:0], 1'b1};
      end else begin
        rb <= tb[63:0];
        qb <= {qb[62:0], 1'b0};
      end
      cnt <= 7'(cnt + 7'd1);
      if (cnt == 7'd63) busy <= 1'b0;
    end
  end

  assign quot_a = qa;
  assign quot_b = qb;
  assign done   = ~busy & ~start;
endmodule

/* hw/rtl/rau_gcd.sv */
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd of two 64-bit magnitudes, one step a cycle
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x_in,
  input  logic [63:0] y_in,
  output logic [63:0] g,
  output logic        done
);
  logic [63:0] x, y;
  logic [6:0]  k;
  logic        busy;

  // stein steps; gcd(x,0)=x
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      x <= x_in;
      y <= y_in;
      k <= '0;
    end else if (busy) begin
      if (x == '0) begin
        x <= y;
        y <= '0;
      end else if (y == '0) begin
        busy <= 1'b0;
      end else if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= 7'(k + 7'd1);
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= (x - y) >> 1;
      end else begin
        y <= (y - x) >> 1;
      end
    end
  end

  assign g    = x << k[5:0];
  assign done = ~busy & ~start;
endmodule

/* hw/rtl/rau_datapath.sv */
// ----------------------------------------------------------------------------
// rau_datapath
// operand decode, products, gcd and divider units, result packing
// ----------------------------------------------------------------------------
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::ctrl_t     ctrl,
  output rau_pkg::stat_t     stat,
  input  logic [2:0]         cmd,
  input  logic [31:0]        lhs_num,
  input  logic [31:0]        lhs_den,
  input  logic [31:0]        rhs_num,
  input  logic [31:0]        rhs_den,
  output logic [63:0]        res_num,
  output logic [63:0]        res_den,
  output logic [1:0]         order,
  output logic [1:0]         status
);
  import rau_pkg::*;

  logic [2:0]  c_r;
  logic [OPERAND_WIDTH-1:0] a_r, b_r, cc_r, d_r;
  logic        as, bs, cs, ds;
  logic [OPERAND_WIDTH-1:0] am, bm, cm, dm;
  logic        early;
  logic [1:0]  early_st;
  logic        ns, dsg;
  logic [63:0] nm, dmg, bq, dq, m1, m2, ord_l, ord_r;
  logic        s1, s2;
  logic [63:0] g_val, g_x, g_y, qa, qb, dvd_a, dvd_b;
  logic        g_done, d_done;
  logic signed [64:0] l_s, r_s;

  function automatic logic [OPERAND_WIDTH-1:0] mag(input logic [OPERAND_WIDTH-1:0] v);
    mag = v[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(-v) : v;
  endfunction

  // capture transaction
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c_r  <= cmd;
      a_r  <= lhs_num[OPERAND_WIDTH-1:0];
      b_r  <= lhs_den[OPERAND_WIDTH-1:0];
      cc_r <= rhs_num[OPERAND_WIDTH-1:0];
      d_r  <= rhs_den[OPERAND_WIDTH-1:0];
    end
  end

  assign as = a_r[OPERAND_WIDTH-1];
  assign bs = b_r[OPERAND_WIDTH-1];
  assign cs = cc_r[OPERAND_WIDTH-1];
  assign ds = d_r[OPERAND_WIDTH-1];
  assign am = mag(a_r);
  assign bm = mag(b_r);
  assign cm = mag(cc_r);
  assign dm = mag(d_r);

  // early decisions
  always_comb begin
    early = 1'b1;
    early_st = ST_OK;
    if (c_r > CMD_CMP) early_st = ST_OK;
    else if (b_r == '0 || d_r == '0) early_st = ST_ZERO;
    else if (c_r == CMD_DIV && cc_r == '0) early_st = ST_ZERO;
    else early = 1'b0;
  end

  assign g_x = ctrl.gcd_sel ? nm : 64'(bm);
  assign g_y = ctrl.gcd_sel ? dmg : 64'(dm);
  assign dvd_a = ctrl.div_sel ? nm : 64'(bm);
  assign dvd_b = ctrl.div_sel ? dmg : 64'(dm);

  rau_gcd u_gcd (
    .clk(clk), .rst(rst), .start(ctrl.gcd_start), .x_in(g_x), .y_in(g_y),
    .g(g_val), .done(g_done)
  );

  rau_divider u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start), .dividend_a(dvd_a),
    .dividend_b(dvd_b), .divisor(g_val), .quot_a(qa), .quot_b(qb),
    .done(d_done)
  );

  // signed cross terms for compare, one multiply each
  assign l_s = 65'(signed'(bs ? -{{33{a_r[OPERAND_WIDTH-1]}}, a_r}
                              : {{33{a_r[OPERAND_WIDTH-1]}}, a_r}));
  assign r_s = 65'(signed'(ds ? -{{33{cc_r[OPERAND_WIDTH-1]}}, cc_r}
                              : {{33{cc_r[OPERAND_WIDTH-1]}}, cc_r}));

  // product and combine stages
  always_ff @(posedge clk) begin
    if (ctrl.prep) begin
      unique case (c_r)
        CMD_MUL: begin
          ns <= as ^ cs; dsg <= bs ^ ds;
          nm <= 64'(am) * 64'(cm); dmg <= 64'(bm) * 64'(dm);
        end
        CMD_DIV: begin
          ns <= as ^ ds; dsg <= bs ^ cs;
          nm <= 64'(am) * 64'(dm); dmg <= 64'(bm) * 64'(cm);
        end
        default: begin
          ns <= 1'b0; dsg <= bs ^ ds;
          nm <= '0; dmg <= '0;
        end
      endcase
      ord_l <= 64'(l_s * signed'(65'(dm)));
      ord_r <= 64'(r_s * signed'(65'(bm)));
    end
    if (ctrl.div_start && !ctrl.div_sel) begin
      // bq, dq follow once divider done
    end
    // reduced denominators never exceed the operand magnitude
    if (ctrl.mul1) begin
      bq <= qa; dq <= qb;
      s1 <= as ^ ds;
      s2 <= (cs ^ bs) ^ (c_r == CMD_SUB);
      m1 <= 64'(am) * 64'(qb[OPERAND_WIDTH-1:0]);
      m2 <= 64'(cm) * 64'(qa[OPERAND_WIDTH-1:0]);
    end
    if (ctrl.mul2) begin
      if (s1 == s2) begin ns <= s1; nm <= 64'(m1 + m2); end
      else if (m1 >= m2) begin ns <= s1; nm <= 64'(m1 - m2); end
      else begin ns <= s2; nm <= 64'(m2 - m1); end
      dmg <= 64'(bq[OPERAND_WIDTH-1:0]) * 64'(dm);
    end
    if (ctrl.fin) begin
      order <= ORD_EQ;
      res_num <= '0;
      res_den <= 64'd1;
      status <= ST_OK;
      if (early) status <= early_st;
      else if (c_r == CMD_CMP) begin
        if (ord_l == ord_r) order <= ORD_EQ;
        else if ($signed(ord_l) < $signed(ord_r)) order <= ORD_LT;
        else order <= ORD_GT;
      end else if (nm != '0) begin
        if ((!((ns ^ dsg) & ns) && qa[63]) || (!((ns ^ dsg) & dsg) && qb[63]) ||
            ((ns ^ dsg) & ns & qa[63] & (qa[62:0] != '0)) ||
            ((ns ^ dsg) & dsg & qb[63] & (qb[62:0] != '0)))
          status <= ST_OVF;
        else begin
          res_num <= ((ns ^ dsg) & ns) ? 64'(-qa) : qa;
          res_den <= ((ns ^ dsg) & dsg) ? 64'(-qb) : qb;
        end
      end
    end
  end

  // for add/sub the numerator is still being combined, so look at the terms
  assign stat.early    = early;
  assign stat.addsub   = (c_r == CMD_ADD) || (c_r == CMD_SUB);
  assign stat.gcd_done = g_done;
  assign stat.div_done = d_done;
  assign stat.nm_zero  = ((c_r == CMD_ADD) || (c_r == CMD_SUB)) ?
                         ((s1 == s2) ? (m1 == '0 && m2 == '0) : (m1 == m2)) :
                         ((nm == '0) || (c_r == CMD_CMP));
endmodule

/* hw/rtl/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencing state machine of the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rau_pkg::ctrl_t ctrl,
  input  rau_pkg::stat_t stat
);
  import rau_pkg::*;

  state_t state, state_next;
  logic   wait1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wait1 <= 1'b0;
    end else begin
      state <= state_next;
      wait1 <= (state != state_next);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_PREP;
      S_PREP: begin
        if (stat.early) state_next = S_FIN;
        else if (stat.addsub) state_next = S_GCD1;
        else state_next = S_MUL2;
      end
      S_GCD1: if (!wait1 && stat.gcd_done) state_next = S_DIV1;
      S_DIV1: if (!wait1 && stat.div_done) state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = stat.nm_zero ? S_FIN : S_GCD2;
      S_GCD2: if (!wait1 && stat.gcd_done) state_next = S_DIV2;
      S_DIV2: if (!wait1 && stat.div_done) state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin in_ready = 1'b1; ctrl.load = 1'b1; end
      S_PREP: ctrl.prep = 1'b1;
      S_GCD1: ctrl.gcd_start = wait1;
      S_DIV1: ctrl.div_start = wait1;
      S_MUL1: ctrl.mul1 = 1'b1;
      S_MUL2: ctrl.mul2 = stat.addsub;
      S_GCD2: begin ctrl.gcd_sel = 1'b1; ctrl.gcd_start = wait1; end
      S_DIV2: begin ctrl.div_sel = 1'b1; ctrl.gcd_sel = 1'b1; ctrl.div_start = wait1; end
      S_FIN:  ctrl.fin = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

/* hw/rtl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add, subtract, multiply, divide and compare with gcd reduction
// ----------------------------------------------------------------------------
// channel  dir  fields
// in_ch    in   cmd, lhs_num, lhs_den, rhs_num, rhs_den
// out_ch   out  res_num, res_den, order, status
//
// one transaction at a time; run time is set by the binary gcd unit and the
// 64-step restoring divider, each run twice for add/subtract (once for a
// zero sum) and once for multiply/divide. errors and unused commands go from
// prep straight to the result; compare and zero products pass through combine.
// synchronous active-high reset returns the sequencer to idle.
// the result is held until the sink takes it; no new input meanwhile.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input logic   clk,
  input logic   rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;
`include "rational_arithmetic_unit_macros.svh"

  ctrl_t ctrl;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .ctrl(ctrl), .stat(stat)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat), .cmd(in_ch.cmd),
    .lhs_num(in_ch.lhs_num), .lhs_den(in_ch.lhs_den), .rhs_num(in_ch.rhs_num),
    .rhs_den(in_ch.rhs_den), .res_num(out_ch.res_num), .res_den(out_ch.res_den),
    .order(out_ch.order), .status(out_ch.status)
  );

  // checks
  `RAU_ASSERT(a_excl, !(in_ch.ready && out_ch.valid), "ready while result pending")
  `RAU_ASSERT_NEXT(a_acc, in_ch.valid && in_ch.ready, !in_ch.ready, "second accept")
  `RAU_ASSERT(a_cmp, !(out_ch.valid && out_ch.order != ORD_EQ) || out_ch.res_num == '0,
    "compare result not zero")
endmodule

/* bench/tb_rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// self-checking bench for fraction add/sub/mul/div/compare with gcd reduction:
// a scoreboard predicts each result from the accepted operands and checks
// every returned transaction in order, under random idling and backpressure
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned NUM_RANDOM  = 630;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned SETTLE      = 500;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] lhs_num;
    logic [31:0] lhs_den;
    logic [31:0] rhs_num;
    logic [31:0] rhs_den;
  } frac_op_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic [1:0]  order;
    logic [1:0]  status;
  } frac_res_t;

  // expected-result store and fraction predictor
  class frac_scoreboard;
    frac_res_t pending_q[$];
    int unsigned errors;

    static function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    static function frac_res_t zero_res(logic [1:0] st);
      frac_res_t r;
      r.res_num = 64'd0;
      r.res_den = 64'd1;
      r.order   = ORD_EQ;
      r.status  = st;
      return r;
    endfunction

    // reduce a sign-magnitude fraction, fold double negatives
    static function frac_res_t reduce(bit nneg, logic [63:0] nm, bit dneg,
                                      logic [63:0] dm);
      logic [63:0] g;
      frac_res_t r;
      if (nm == 0) return zero_res(ST_OK);
      g = gcd64(nm, dm);
      nm = nm / g;
      dm = dm / g;
      if (nneg && dneg) begin
        nneg = 0;
        dneg = 0;
      end
      if ((nm > 64'h7FFF_FFFF_FFFF_FFFF && !(nneg && nm == 64'h8000_0000_0000_0000)) ||
          (dm > 64'h7FFF_FFFF_FFFF_FFFF && !(dneg && dm == 64'h8000_0000_0000_0000)))
        return zero_res(ST_OVF);
      r.res_num = nneg ? -nm : nm;
      r.res_den = dneg ? -dm : dm;
      r.order   = ORD_EQ;
      r.status  = ST_OK;
      return r;
    endfunction

    static function frac_res_t predict(frac_op_t op);
      longint a, b, c, d, l, rr;
      logic [63:0] am, bm, cm, dm, g, bq, dq, m1, m2, nm;
      bit as, bs, cs, ds, s1, s2, ns;
      frac_res_t r;
      a = longint'($signed(op.lhs_num));
      b = longint'($signed(op.lhs_den));
      c = longint'($signed(op.rhs_num));
      d = longint'($signed(op.rhs_den));
      as = a < 0; bs = b < 0; cs = c < 0; ds = d < 0;
      am = as ? -a : a; bm = bs ? -b : b;
      cm = cs ? -c : c; dm = ds ? -d : d;
      if (op.cmd > CMD_CMP) return zero_res(ST_OK);
      if (b == 0 || d == 0) return zero_res(ST_ZERO);
      case (op.cmd)
        CMD_ADD, CMD_SUB: begin
          g  = gcd64(bm, dm);
          bq = bm / g;
          dq = dm / g;
          s1 = as != ds;
          m1 = am * dq;
          s2 = (cs != bs) != (op.cmd == CMD_SUB);
          m2 = cm * bq;
          if (s1 == s2) begin
            ns = s1; nm = m1 + m2;
          end else if (m1 >= m2) begin
            ns = s1; nm = m1 - m2;
          end else begin
            ns = s2; nm = m2 - m1;
          end
          return reduce(ns, nm, bs != ds, bq * dm);
        end
        CMD_MUL: return reduce(as != cs, am * cm, bs != ds, bm * dm);
        CMD_DIV: begin
          if (c == 0) return zero_res(ST_ZERO);
          return reduce(as != ds, am * dm, bs != cs, bm * cm);
        end
        default: begin
          // cross products scaled by |b|*|d|
          l  = (bs ? -a : a) * longint'(dm);
          rr = (ds ? -c : c) * longint'(bm);
          r  = zero_res(ST_OK);
          r.order = (l == rr) ? ORD_EQ : ((l < rr) ? ORD_LT : ORD_GT);
          return r;
        end
      endcase
    endfunction

    function void note_operands(frac_op_t op);
      pending_q.push_back(predict(op));
    endfunction

    function void check_result(frac_res_t got);
      frac_res_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp/got: num %h/%h den %h/%h ord %0d/%0d st %0d/%0d",
                   want.res_num, got.res_num, want.res_den, got.res_den,
                   want.order, got.order, want.status, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  frac_scoreboard sb = new();
  bit quiet_phase;
  bit hold_req;
  int unsigned cycle_cnt;

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[rational_arithmetic_unit] ERROR");
      $finish;
    end
  end

  // transaction monitors
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_operands({in_ch.cmd, in_ch.lhs_num, in_ch.lhs_den, in_ch.rhs_num,
                        in_ch.rhs_den});
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.res_num, out_ch.res_den, out_ch.order, out_ch.status});
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int unsigned n;
    out_ch.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet_phase && $urandom_range(7) == 0) begin
        n = $urandom_range(14, 1);
        out_ch.ready <= 0;
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1;
        @(negedge clk);
      end
    end
  end

  // ready is looked at between edges, where it is stable
  task automatic send_op(frac_op_t op);
    int unsigned n;
    if (!quiet_phase && $urandom_range(5) == 0) begin
      n = $urandom_range(14, 1);
      in_ch.valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid   <= 1;
    in_ch.cmd     <= op.cmd;
    in_ch.lhs_num <= op.lhs_num;
    in_ch.lhs_den <= op.lhs_den;
    in_ch.rhs_num <= op.rhs_num;
    in_ch.rhs_den <= op.rhs_den;
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send5(logic [2:0] cmd, int a, int b, int c, int d);
    send_op({cmd, a, b, c, d});
  endtask

  // operand of mixed magnitude
  function automatic logic [31:0] rand_part(bit nonzero);
    logic [31:0] v;
    do begin
      case ($urandom_range(4))
        0: v = $urandom_range(40) - 20;
        1: v = $urandom;
        2: v = ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF) + $urandom_range(2);
        3: v = ($urandom_range(360) + 1) * ($urandom_range(1) ? 1 : -1) * 12;
        default: v = ($urandom_range(65535) - 32768) * 64;
      endcase
    end while (nonzero && v == 0);
    return v;
  endfunction

  initial begin
    frac_op_t op;
    in_ch.valid   = 0;
    in_ch.cmd     = CMD_ADD;
    in_ch.lhs_num = 0;
    in_ch.lhs_den = 1;
    in_ch.rhs_num = 0;
    in_ch.rhs_den = 1;
    quiet_phase = 0;
    hold_req = 0;
    cycle_cnt = 0;
    rst = 1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: each command, sign cases, extremes, error cases
    send5(CMD_ADD, 1, 2, 1, 3);
    send5(CMD_SUB, 1, 2, 1, 2);
    send5(CMD_MUL, -3, 4, 2, -9);
    send5(CMD_DIV, -3, -4, 6, 8);
    send5(CMD_CMP, 1, 3, 2, 6);
    send5(CMD_CMP, -1, 3, 1, -4);
    send5(CMD_CMP, 5, -7, -1, 2);
    send5(CMD_ADD, -5, -6, -7, -8);
    send5(CMD_MUL, 0, -5, 7, 3);
    send5(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send5(CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFE);
    send5(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send5(CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send5(CMD_CMP, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    send5(CMD_ADD, 1, 0, 1, 1);
    send5(CMD_SUB, 1, 1, 1, 0);
    send5(CMD_CMP, 1, 0, 1, 0);
    send5(CMD_DIV, 3, 4, 0, 5);
    send5(CMD_MUL, 3, 0, 0, 5);
    send5(3'd5, 1, 2, 3, 4);
    send5(3'd6, 1, 0, 3, 0);
    send5(3'd7, -1, -1, -1, -1);
    send5(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random: mostly well-formed operands, some errors and unused commands
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 100) hold_req = 1;
      if (i == NUM_RANDOM - 80) quiet_phase = 1;
      op.cmd = 3'($urandom_range(4));
      op.lhs_num = rand_part(0);
      op.lhs_den = rand_part(1);
      op.rhs_num = rand_part(0);
      op.rhs_den = rand_part(1);
      case ($urandom_range(19))
        0: op.lhs_den = 0;
        1: op.rhs_den = 0;
        2: op.cmd = 3'($urandom_range(7, 5));
        3: begin
          op.cmd = CMD_DIV;
          op.rhs_num = 0;
        end
        default: ;
      endcase
      send_op(op);
    end
    in_ch.valid <= 0;

    // drain
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("[rational_arithmetic_unit] OK");
    else
      $display("[rational_arithmetic_unit] ERROR");
    $finish;
  end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_if.sv
hw/rtl/rau_divider.sv
hw/rtl/rau_gcd.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rational_arithmetic_unit.sv
bench/tb_rational_arithmetic_unit.sv
